@@ rtl/i2r_pkg.sv @@
`timescale 1ns / 1ps

package i2r_pkg;

  // ASCII codes of the Roman symbols
  localparam logic [6:0] SYM_NONE = 7'h00;
  localparam logic [6:0] SYM_I    = 7'h49;
  localparam logic [6:0] SYM_V    = 7'h56;
  localparam logic [6:0] SYM_X    = 7'h58;
  localparam logic [6:0] SYM_L    = 7'h4C;
  localparam logic [6:0] SYM_C    = 7'h43;
  localparam logic [6:0] SYM_D    = 7'h44;
  localparam logic [6:0] SYM_M    = 7'h4D;

  localparam logic [11:0] MAX_VALUE = 12'd3999;

  // decimal places, most significant first
  localparam int unsigned NUM_PLACES = 4;
  localparam logic [1:0] PLACE_THOUSANDS = 2'd0;
  localparam logic [1:0] PLACE_HUNDREDS  = 2'd1;
  localparam logic [1:0] PLACE_TENS      = 2'd2;
  localparam logic [1:0] PLACE_UNITS     = 2'd3;

  typedef logic [3:0] digit_t;

  // one classified item handed from the front to the back
  typedef struct packed {
    logic                         err;
    logic [NUM_PLACES-1:0][3:0]   dig;
  } entry_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIGIT,
    FE_PUSH
  } fe_state_t;

  // k times the weight of a decimal place
  function automatic logic [13:0] place_mult(input logic [1:0] p, input digit_t k);
    logic [13:0] w;
    case (p)
      PLACE_THOUSANDS: w = 14'd1000;
      PLACE_HUNDREDS:  w = 14'd100;
      PLACE_TENS:      w = 14'd10;
      default:         w = 14'd1;
    endcase
    return 14'({10'd0, k} * w);
  endfunction

  // number of symbols a decimal digit takes
  function automatic logic [2:0] digit_len(input digit_t d);
    case (d)
      4'd0:    return 3'd0;
      4'd1:    return 3'd1;
      4'd2:    return 3'd2;
      4'd3:    return 3'd3;
      4'd4:    return 3'd2;
      4'd5:    return 3'd1;
      4'd6:    return 3'd2;
      4'd7:    return 3'd3;
      4'd8:    return 3'd4;
      4'd9:    return 3'd2;
      default: return 3'd0;
    endcase
  endfunction

  // symbol number k of digit d at place p
  function automatic logic [6:0] roman_sym(input logic [1:0] p, input digit_t d,
                                           input logic [1:0] k);
    logic [6:0] one_s;
    logic [6:0] five_s;
    logic [6:0] ten_s;
    logic [6:0] s;
    case (p)
      PLACE_THOUSANDS: begin
        one_s = SYM_M; five_s = SYM_NONE; ten_s = SYM_NONE;
      end
      PLACE_HUNDREDS: begin
        one_s = SYM_C; five_s = SYM_D; ten_s = SYM_M;
      end
      PLACE_TENS: begin
        one_s = SYM_X; five_s = SYM_L; ten_s = SYM_C;
      end
      default: begin
        one_s = SYM_I; five_s = SYM_V; ten_s = SYM_X;
      end
    endcase
    case (d) inside
      [4'd0:4'd3]: s = one_s;
      4'd4:        s = (k == 2'd0) ? one_s : five_s;
      [4'd5:4'd8]: s = (k == 2'd0) ? five_s : one_s;
      default:     s = (k == 2'd0) ? one_s : ten_s;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/i2r_front.sv @@
`timescale 1ns / 1ps

module i2r_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [11:0]        value,
  output logic               wr_en,
  input  logic               q_full,
  output i2r_pkg::entry_t    wr_data
);

  i2r_pkg::fe_state_t state;
  i2r_pkg::fe_state_t state_next;

  logic [11:0] rem;
  logic [1:0]  place;
  logic        err;
  logic [i2r_pkg::NUM_PLACES-1:0][3:0] dig;

  logic [3:0]  digit;
  logic [13:0] digit_weight;
  logic        accept;

  // count how many multiples of the place weight fit in the remainder
  always_comb begin
    digit = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({2'b00, rem} >= i2r_pkg::place_mult(place, 4'(k))) begin
        digit = digit + 4'd1;
      end
    end
    digit_weight = i2r_pkg::place_mult(place, digit);
  end

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i2r_pkg::FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    full       = 1'b1;
    wr_en      = 1'b0;
    case (state)
      i2r_pkg::FE_IDLE: begin
        full = 1'b0;
        if (push) begin
          if (value == 12'd0 || value > i2r_pkg::MAX_VALUE) begin
            state_next = i2r_pkg::FE_PUSH;
          end else begin
            state_next = i2r_pkg::FE_DIGIT;
          end
        end
      end
      i2r_pkg::FE_DIGIT: begin
        if (place == i2r_pkg::PLACE_UNITS) begin
          state_next = i2r_pkg::FE_PUSH;
        end
      end
      i2r_pkg::FE_PUSH: begin
        if (!q_full) begin
          wr_en      = 1'b1;
          state_next = i2r_pkg::FE_IDLE;
        end
      end
      default: state_next = i2r_pkg::FE_IDLE;
    endcase
  end

  // take the value apart one decimal place per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rem   <= value;
      place <= i2r_pkg::PLACE_THOUSANDS;
      err   <= (value == 12'd0) || (value > i2r_pkg::MAX_VALUE);
    end else if (state == i2r_pkg::FE_DIGIT) begin
      dig[place] <= digit;
      rem        <= rem - digit_weight[11:0];
      place      <= place + 2'd1;
    end
  end

  assign wr_data.err = err;
  assign wr_data.dig = dig;

endmodule

@@ rtl/i2r_queue.sv @@
`timescale 1ns / 1ps

module i2r_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  i2r_pkg::entry_t    wr_data,
  output logic               full,
  input  logic               rd_en,
  output i2r_pkg::entry_t    rd_data,
  output logic               empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  i2r_pkg::entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> !empty) else $error("queue read while empty");
  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !rd_en) |=> count == $past(count) + CW'(1))
    else $error("queue count did not advance on write");
`endif

endmodule

@@ rtl/i2r_back.sv @@
`timescale 1ns / 1ps

module i2r_back (
  input  logic               clk,
  input  logic               rst,
  input  i2r_pkg::entry_t    rd_data,
  input  logic               q_empty,
  output logic               rd_en,
  output logic               empty,
  input  logic               pop,
  output logic [6:0]         symbol,
  output logic               last,
  output logic               error
);

  logic       started;
  logic [1:0] p;
  logic [1:0] k;
  logic       out_valid;

  logic [3:0] nz;
  logic [1:0] first_nz;
  logic [1:0] cur_p;
  logic [1:0] next_p;
  logic       more;
  logic [3:0] d;
  logic [2:0] len;
  logic       k_last;
  logic       emit;
  logic       emit_last;
  logic [6:0] emit_sym;

  always_comb begin
    for (int i = 0; i < i2r_pkg::NUM_PLACES; i++) begin
      nz[i] = (rd_data.dig[i] != 4'd0);
    end
    first_nz = 2'd0;
    for (int i = i2r_pkg::NUM_PLACES - 1; i >= 0; i--) begin
      if (nz[i]) begin
        first_nz = 2'(i);
      end
    end
    cur_p  = started ? p : first_nz;
    more   = 1'b0;
    next_p = cur_p;
    for (int i = i2r_pkg::NUM_PLACES - 1; i >= 0; i--) begin
      if (nz[i] && 2'(i) > cur_p) begin
        more   = 1'b1;
        next_p = 2'(i);
      end
    end
    d      = rd_data.dig[cur_p];
    len    = i2r_pkg::digit_len(d);
    k_last = ({1'b0, k} + 3'd1 == len);
    if (rd_data.err) begin
      emit_sym  = i2r_pkg::SYM_NONE;
      emit_last = 1'b1;
    end else begin
      emit_sym  = i2r_pkg::roman_sym(cur_p, d, k);
      emit_last = k_last && !more;
    end
  end

  // a queued symbol enters the output register when it is free or drained
  assign emit  = !q_empty && (!out_valid || pop);
  assign rd_en = emit && emit_last;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      p         <= 2'd0;
      k         <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        if (emit_last) begin
          started <= 1'b0;
          k       <= 2'd0;
        end else if (k_last) begin
          started <= 1'b1;
          p       <= next_p;
          k       <= 2'd0;
        end else begin
          started <= 1'b1;
          p       <= cur_p;
          k       <= k + 2'd1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      symbol <= emit_sym;
      last   <= emit_last;
      error  <= rd_data.err;
    end
  end

`ifndef NO_ASSERTIONS
  a_error_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error) |-> (last && symbol == i2r_pkg::SYM_NONE))
    else $error("error beat is not a single empty symbol");
  a_entry_done: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> (!started && k == 2'd0 && last))
    else $error("entry released without its final beat");
`endif

endmodule

@@ rtl/integer_to_roman_numeral_encoder.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         push / full        value[11:0]
// result    out        pop / empty        symbol[6:0], last, error
//
// One input beat yields one result beat per Roman character, 1 to 15 beats,
// one per cycle while pop keeps up; the longest numeral (3888) gives 15.
// The front end accepts the value, splits it into decimal digits
// (one place per cycle) and queues it once the queue has room.
// Zero or values above 3999 give a single beat with error set and symbol 0;
// they skip the split, so the front goes from accepting straight to queueing.
// Reset (rst, synchronous) empties the queue and the output register.
// Full stays high while the front works on an item and while it holds a
// finished item for a full queue. A stalled result (pop low) holds the back
// end; the front keeps filling the queue until it is full.
module integer_to_roman_numeral_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [11:0] value,
  output logic        empty,
  input  logic        pop,
  output logic [6:0]  symbol,
  output logic        last,
  output logic        error
);

  // classified items travel between front and back through this queue
  i2r_pkg::entry_t wr_data;
  i2r_pkg::entry_t rd_data;
  logic            wr_en;
  logic            q_full;
  logic            rd_en;
  logic            q_empty;

  // front: accept, range check, split into thousands/hundreds/tens/units
  i2r_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .value   (value),
    .wr_en   (wr_en),
    .q_full  (q_full),
    .wr_data (wr_data)
  );

  // decouple digit extraction from symbol emission
  i2r_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .full    (q_full),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .empty   (q_empty)
  );

  // back: walk nonzero digits, one symbol per unstalled cycle into output reg
  i2r_back u_back (
    .clk     (clk),
    .rst     (rst),
    .rd_data (rd_data),
    .q_empty (q_empty),
    .rd_en   (rd_en),
    .empty   (empty),
    .pop     (pop),
    .symbol  (symbol),
    .last    (last),
    .error   (error)
  );

endmodule
